// File: sv/fbpid_pkg.sv
// Package for the flywheel bang/ID speed controller.
// Field widths, register indexes, reset values and accumulator sizing.
// No dependencies; used by the interfaces and all modules.
package fbpid_pkg;

  // Gain fraction bits of the Q-format integral and derivative gains.
  localparam int GAIN_FRAC_BITS = 8;

  // Field widths.
  localparam int SPEED_W  = 12;
  localparam int TARGET_W = 11;
  localparam int BAND_W   = 8;
  localparam int GAIN_W   = 8;
  localparam int POWER_W  = 7;
  localparam int EST_W    = 16;
  localparam int ERR_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Product widths: 9-bit signed gain times 13/14-bit signed error terms.
  localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + ERR_W + 1;
  // Sum width covers the shifted accumulator and both products with headroom.
  localparam int SUM_BASE_W = ((EST_W + GAIN_FRAC_BITS) > PROD_D_W) ?
                              (EST_W + GAIN_FRAC_BITS) : PROD_D_W;
  localparam int SUM_W = SUM_BASE_W + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED    = 2'd0,
    CFG_BANG_BAND       = 2'd1,
    CFG_INTEGRAL_GAIN   = 2'd2,
    CFG_DERIVATIVE_GAIN = 2'd3
  } cfg_idx_t;

  // Mode codes.
  localparam logic MODE_BANG = 1'b0;
  localparam logic MODE_ID   = 1'b1;

  // Reset values and limits.
  localparam logic [TARGET_W-1:0] TARGET_RST   = 11'd420;
  localparam logic [BAND_W-1:0]   BAND_RST     = 8'd5;
  localparam logic [GAIN_W-1:0]   KI_RST       = 8'd10;
  localparam logic [GAIN_W-1:0]   KD_RST       = 8'd128;
  localparam logic signed [EST_W-1:0] ACC_RST  = 16'sd100;
  localparam logic [POWER_W-1:0]  POWER_FULL   = 7'd127;

endpackage

// File: sv/fbpid_if.sv
// Channel interfaces for the flywheel speed controller: tick input,
// result output and configuration write. Depends on fbpid_pkg.

interface fbpid_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fbpid_pkg::SPEED_W-1:0] measured_speed;
  logic                                enable;
  modport source (output valid, output measured_speed, output enable, input ready);
  modport sink   (input valid, input measured_speed, input enable, output ready);
endinterface

interface fbpid_out_if;
  logic                                valid;
  logic                                ready;
  logic [fbpid_pkg::POWER_W-1:0]       motor_power;
  logic                                mode;
  logic signed [fbpid_pkg::EST_W-1:0]  power_estimate;
  modport source (output valid, output motor_power, output mode, output power_estimate,
                  input ready);
  modport sink   (input valid, input motor_power, input mode, input power_estimate,
                  output ready);
endinterface

interface fbpid_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fbpid_pkg::CFG_IDX_W-1:0]     index;
  logic [fbpid_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/flywheel_bang_pid_speed_control_top.sv
// Top level of the flywheel bang/ID speed controller.
// Depends on fbpid_pkg and the channel interfaces in fbpid_if.sv.
//
// Usage: every request on in_chan is one control tick carrying the measured
// speed and an enable bit. Each tick yields exactly one result request on
// out_chan with the applied motor power, the mode (bang or ID regulation) and
// the accumulated power estimate. The cfg_chan port writes the target speed,
// bang band and the two Q8 gains; it is always ready and should be written
// only while no tick is in flight.
//
// A tick accepted at a clock edge is held in the input register; when the
// result register is free, a single pass of error, mode, multiply and
// accumulate logic carries it into the result register, which then drives
// the result request. Throughput is one tick per clock while the receiver
// takes results; the state registers update together with the result register,
// which closes the loop between ticks.
//
// Reset (synchronous, active low) restores the register defaults, clears the
// previous error and applied power, selects bang mode and sets the power
// estimate to 100. When the receiver stalls, the result register holds and
// the input register absorbs one more tick before in_chan deasserts ready.
module flywheel_bang_pid_speed_control_top (
  input  logic         clk,
  input  logic         rst_n,
  fbpid_in_if.sink     in_chan,
  fbpid_out_if.source  out_chan,
  fbpid_cfg_if.sink    cfg_chan
);

  localparam int F  = fbpid_pkg::GAIN_FRAC_BITS;
  localparam int SW = fbpid_pkg::SUM_W;

  // Configuration registers.
  logic [fbpid_pkg::TARGET_W-1:0] target_r;
  logic [fbpid_pkg::BAND_W-1:0]   band_r;
  logic [fbpid_pkg::GAIN_W-1:0]   ki_r;
  logic [fbpid_pkg::GAIN_W-1:0]   kd_r;

  // Input register stage.
  logic                                 s1_valid_r;
  logic signed [fbpid_pkg::SPEED_W-1:0] s1_speed_r;
  logic                                 s1_enable_r;

  // Controller state.
  logic signed [fbpid_pkg::ERR_W-1:0]   prev_err_r;
  logic signed [fbpid_pkg::EST_W-1:0]   acc_r;
  logic                                 mode_r;
  logic [fbpid_pkg::POWER_W-1:0]        power_r;

  // Result register.
  logic                                 out_valid_r;
  logic [fbpid_pkg::POWER_W-1:0]        out_power_r;
  logic                                 out_mode_r;
  logic signed [fbpid_pkg::EST_W-1:0]   out_est_r;

  // Datapath signals.
  logic                                 advance;
  logic signed [fbpid_pkg::ERR_W-1:0]   speed_ext;
  logic signed [fbpid_pkg::ERR_W-1:0]   err;
  logic signed [fbpid_pkg::ERR_W-1:0]   thresh;
  logic signed [fbpid_pkg::ERR_W:0]     err_diff;
  logic signed [fbpid_pkg::PROD_I_W-1:0] prod_i;
  logic signed [fbpid_pkg::PROD_D_W-1:0] prod_d;
  logic signed [SW-1:0]                 sum;
  logic signed [SW-1:0]                 quot;
  logic signed [SW-1:0]                 quot_rnd;
  logic signed [fbpid_pkg::EST_W-1:0]   acc_sat;
  logic [fbpid_pkg::POWER_W-1:0]        acc_clamp;
  logic                                 mode_nxt;
  logic signed [fbpid_pkg::ERR_W-1:0]   prev_err_nxt;
  logic signed [fbpid_pkg::EST_W-1:0]   acc_nxt;
  logic [fbpid_pkg::POWER_W-1:0]        power_nxt;

  // The result register frees when it is empty or being taken; the input
  // register then moves forward and can take a new tick in the same cycle.
  assign advance        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !s1_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.motor_power    = out_power_r;
  assign out_chan.mode           = out_mode_r;
  assign out_chan.power_estimate = out_est_r;

  // Error and band threshold, both as 13-bit signed values.
  assign speed_ext = {s1_speed_r[fbpid_pkg::SPEED_W-1], s1_speed_r};
  assign err       = $signed({2'b00, target_r}) - speed_ext;
  assign thresh    = $signed({2'b00, target_r}) - $signed({5'b00000, band_r});
  assign err_diff  = {prev_err_r[fbpid_pkg::ERR_W-1], prev_err_r}
                   - {err[fbpid_pkg::ERR_W-1], err};

  // Gains are unsigned, so each gets a zero sign bit before the multiply.
  assign prod_i = $signed({1'b0, ki_r}) * err;
  assign prod_d = $signed({1'b0, kd_r}) * err_diff;

  // Accumulate in Q(F), then divide by 2^F truncating toward zero: the
  // arithmetic shift floors, so negative sums with a remainder get one back.
  assign sum = ($signed({{(SW-fbpid_pkg::EST_W){acc_r[fbpid_pkg::EST_W-1]}}, acc_r}) <<< F)
             + $signed({{(SW-fbpid_pkg::PROD_I_W){prod_i[fbpid_pkg::PROD_I_W-1]}}, prod_i})
             + $signed({{(SW-fbpid_pkg::PROD_D_W){prod_d[fbpid_pkg::PROD_D_W-1]}}, prod_d});
  assign quot     = sum >>> F;
  assign quot_rnd = quot + $signed({{(SW-1){1'b0}},
                                    (sum[SW-1] && (|sum[F-1:0]))});

  always_comb begin
    // Saturate to 16 bits: the value fits when all upper bits match the sign.
    if ((&quot_rnd[SW-1:fbpid_pkg::EST_W-1]) || !(|quot_rnd[SW-1:fbpid_pkg::EST_W-1])) begin
      acc_sat = quot_rnd[fbpid_pkg::EST_W-1:0];
    end else if (quot_rnd[SW-1]) begin
      acc_sat = {1'b1, {(fbpid_pkg::EST_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(fbpid_pkg::EST_W-1){1'b1}}};
    end
  end

  // Clamp the estimate to the motor range 0..127.
  always_comb begin
    if (acc_sat[fbpid_pkg::EST_W-1]) begin
      acc_clamp = '0;
    end else if (|acc_sat[fbpid_pkg::EST_W-2:fbpid_pkg::POWER_W]) begin
      acc_clamp = fbpid_pkg::POWER_FULL;
    end else begin
      acc_clamp = acc_sat[fbpid_pkg::POWER_W-1:0];
    end
  end

  // Next state for the tick in the input register.
  always_comb begin
    mode_nxt     = mode_r;
    prev_err_nxt = prev_err_r;
    acc_nxt      = acc_r;
    power_nxt    = power_r;
    if (s1_enable_r) begin
      prev_err_nxt = err;
      // Exactly at the band edge the previous mode stays.
      if (speed_ext < thresh) begin
        mode_nxt = fbpid_pkg::MODE_BANG;
      end else if (speed_ext > thresh) begin
        mode_nxt = fbpid_pkg::MODE_ID;
      end
      if (mode_nxt == fbpid_pkg::MODE_BANG) begin
        power_nxt = fbpid_pkg::POWER_FULL;
      end else begin
        acc_nxt   = acc_sat;
        power_nxt = acc_clamp;
      end
    end else if (power_r != '0) begin
      // Disabled ticks ramp the motor down one step at a time.
      power_nxt = power_r - {{(fbpid_pkg::POWER_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= fbpid_pkg::TARGET_RST;
      band_r      <= fbpid_pkg::BAND_RST;
      ki_r        <= fbpid_pkg::KI_RST;
      kd_r        <= fbpid_pkg::KD_RST;
      s1_valid_r  <= 1'b0;
      prev_err_r  <= '0;
      acc_r       <= fbpid_pkg::ACC_RST;
      mode_r      <= fbpid_pkg::MODE_BANG;
      power_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (fbpid_pkg::cfg_idx_t'(cfg_chan.index))
          fbpid_pkg::CFG_TARGET_SPEED:    target_r <= cfg_chan.data;
          fbpid_pkg::CFG_BANG_BAND:       band_r   <= cfg_chan.data[fbpid_pkg::BAND_W-1:0];
          fbpid_pkg::CFG_INTEGRAL_GAIN:   ki_r     <= cfg_chan.data[fbpid_pkg::GAIN_W-1:0];
          fbpid_pkg::CFG_DERIVATIVE_GAIN: kd_r     <= cfg_chan.data[fbpid_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          prev_err_r <= prev_err_nxt;
          acc_r      <= acc_nxt;
          mode_r     <= mode_nxt;
          power_r    <= power_nxt;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_speed_r  <= in_chan.measured_speed;
      s1_enable_r <= in_chan.enable;
    end
    if (advance && s1_valid_r) begin
      out_power_r <= power_nxt;
      out_mode_r  <= mode_nxt;
      out_est_r   <= acc_nxt;
    end
  end

endmodule

// File: sv/fbpid_checker.sv
// Port-level checker for the flywheel speed controller top level.
// Depends on fbpid_pkg; bound to flywheel_bang_pid_speed_control_top below.
module fbpid_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [fbpid_pkg::POWER_W-1:0]       out_power,
  input logic                                out_mode,
  input logic signed [fbpid_pkg::EST_W-1:0]  out_est
);

  // A result never shows in the cycle right after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A result appearing from an empty output comes from a tick taken through the input register.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching tick");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_power) && $stable(out_mode) && $stable(out_est)))
    else $error("result changed while stalled");

endmodule

bind flywheel_bang_pid_speed_control_top fbpid_checker u_fbpid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_power (out_chan.motor_power),
  .out_mode  (out_chan.mode),
  .out_est   (out_chan.power_estimate)
);
